// ----- design/ptrd_pkg.sv -----
// Shared types, constants and helper functions for the packed tuple row decoder.
// No dependencies; every other design file imports this package.
package ptrd_pkg;

    localparam int FIELD_BITS = 64;
    localparam int WIDTH_BITS = 7;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VALUE_WIDTH  = 2'd2;

    typedef enum logic [1:0] {
        PH_COLUMN = 2'd0,
        PH_COUNT  = 2'd1,
        PH_VALUE  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_COLUMN  = 2'd0,
        KIND_COUNT   = 2'd1,
        KIND_VALUE   = 2'd2,
        KIND_ROW_END = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_SCAN    = 2'd1,
        ST_ROW_END = 2'd2
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish_row;
    } dp_cmd_t;

    typedef struct packed {
        logic chunk_empty;
        logic row_end;
        logic out_free;
    } dp_status_t;

    function automatic logic [WIDTH_BITS-1:0] clamp_width(input logic [WIDTH_BITS-1:0] w);
        logic [WIDTH_BITS-1:0] r;
        if (w == '0)
            r = WIDTH_BITS'(1);
        else if (w > WIDTH_BITS'(FIELD_BITS))
            r = WIDTH_BITS'(FIELD_BITS);
        else
            r = w;
        return r;
    endfunction

    function automatic kind_t phase_kind(input phase_t ph);
        kind_t k;
        case (ph)
            PH_COLUMN: k = KIND_COLUMN;
            PH_COUNT:  k = KIND_COUNT;
            PH_VALUE:  k = KIND_VALUE;
            default:   k = KIND_COLUMN;
        endcase
        return k;
    endfunction

endpackage

// ----- design/ptrd_ctrl.sv -----
// Controller state machine of the packed tuple row decoder.
// Depends on ptrd_pkg; drives the datapath through dp_cmd_t and reads dp_status_t.
module ptrd_ctrl
    import ptrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.chunk_empty)
                    state_next = status.row_end ? ST_ROW_END : ST_IDLE;
                else if (status.out_free)
                    cmd.step = 1'b1;
            end
            ST_ROW_END:
            begin
                if (status.out_free)
                begin
                    cmd.finish_row = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/ptrd_datapath.sv -----
// Datapath of the packed tuple row decoder: width registers, chunk shifter,
// field assembly, record state, row counter and the result register.
// Depends on ptrd_pkg; sequenced by ptrd_ctrl.
module ptrd_datapath
    import ptrd_pkg::*;
#(
    parameter int CHUNK_BITS = 32,
    parameter int ROW_NUMBER_BITS = 40
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WIDTH_BITS-1:0]     cfg_data,
    input  logic [CHUNK_BITS-1:0]     chunk,
    input  logic [5:0]                chunk_bits,
    input  logic                      row_end,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [1:0]                kind,
    output logic [FIELD_BITS-1:0]     field_value,
    output logic                      malformed,
    output logic                      last
);

    localparam int RW = $clog2(CHUNK_BITS + 1);

    logic [WIDTH_BITS-1:0]      col_w_reg;
    logic [WIDTH_BITS-1:0]      cnt_w_reg;
    logic [WIDTH_BITS-1:0]      val_w_reg;
    logic [CHUNK_BITS-1:0]      sh_reg;
    logic [CHUNK_BITS-1:0]      sh_next;
    logic [RW-1:0]              rem_reg;
    logic [RW-1:0]              rem_next;
    logic                       end_reg;
    logic [FIELD_BITS-1:0]      buf_reg;
    logic [FIELD_BITS-1:0]      buf_next;
    logic [WIDTH_BITS-1:0]      fill_reg;
    logic [WIDTH_BITS-1:0]      fill_next;
    phase_t                     phase_reg;
    phase_t                     phase_next;
    logic [FIELD_BITS-1:0]      left_reg;
    logic [FIELD_BITS-1:0]      left_next;
    logic [ROW_NUMBER_BITS-1:0] row_cnt_reg;
    logic                       out_valid_reg;
    kind_t                      out_kind_reg;
    logic [FIELD_BITS-1:0]      out_value_reg;
    logic                       out_bad_reg;
    logic                       out_last_reg;

    logic [5:0]                 n_sat;
    logic [WIDTH_BITS-1:0]      w_cur;
    logic [WIDTH_BITS-1:0]      w_next;
    logic [WIDTH_BITS-1:0]      need;
    logic [WIDTH_BITS-1:0]      rem_ext;
    logic [WIDTH_BITS-1:0]      take;
    logic [CHUNK_BITS-1:0]      piece;
    logic [FIELD_BITS-1:0]      merged;
    logic [WIDTH_BITS-1:0]      fill_sum;
    logic                       done;
    logic [FIELD_BITS-1:0]      fvalue;
    logic [RW-1:0]              rem_after;
    logic [FIELD_BITS-1:0]      left_dec;
    phase_t                     ph_after;
    logic [FIELD_BITS-1:0]      left_after;
    logic                       last_field;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_w_reg <= WIDTH_BITS'(1);
            cnt_w_reg <= WIDTH_BITS'(1);
            val_w_reg <= WIDTH_BITS'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COLUMN_WIDTH: col_w_reg <= cfg_data;
                REG_COUNT_WIDTH:  cnt_w_reg <= cfg_data;
                REG_VALUE_WIDTH:  val_w_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Field step: take as many chunk bits as the current field still needs, up to the bits left in the chunk.
    always_comb
    begin
        n_sat = (chunk_bits > 6'(CHUNK_BITS)) ? 6'(CHUNK_BITS) : chunk_bits;

        case (phase_reg)
            PH_COLUMN: w_cur = clamp_width(col_w_reg);
            PH_COUNT:  w_cur = clamp_width(cnt_w_reg);
            default:   w_cur = clamp_width(val_w_reg);
        endcase

        need      = (fill_reg >= w_cur) ? WIDTH_BITS'(1) : w_cur - fill_reg;
        rem_ext   = WIDTH_BITS'(rem_reg);
        take      = (need < rem_ext) ? need : rem_ext;
        piece     = sh_reg & ~({CHUNK_BITS{1'b1}} << take);
        merged    = buf_reg | (FIELD_BITS'(piece) << fill_reg);
        fill_sum  = fill_reg + take;
        done      = fill_sum >= w_cur;
        fvalue    = merged & ~({FIELD_BITS{1'b1}} << w_cur);
        rem_after = rem_reg - RW'(take);
        left_dec  = left_reg - FIELD_BITS'(1);

        ph_after   = phase_reg;
        left_after = left_reg;
        case (phase_reg)
            PH_COLUMN:
            begin
                ph_after = PH_COUNT;
            end
            PH_COUNT:
            begin
                left_after = fvalue;
                ph_after   = (fvalue == '0) ? PH_COLUMN : PH_VALUE;
            end
            PH_VALUE:
            begin
                left_after = left_dec;
                ph_after   = (left_dec == '0) ? PH_COLUMN : PH_VALUE;
            end
            default:
            begin
                ph_after = PH_COLUMN;
            end
        endcase

        case (ph_after)
            PH_COLUMN: w_next = clamp_width(col_w_reg);
            PH_COUNT:  w_next = clamp_width(cnt_w_reg);
            default:   w_next = clamp_width(val_w_reg);
        endcase

        // The next field starts empty, so it completes in this transfer only
        // if the bits left cover its whole width.
        last_field = !end_reg && (WIDTH_BITS'(rem_after) < w_next);

        sh_next    = sh_reg;
        rem_next   = rem_reg;
        buf_next   = buf_reg;
        fill_next  = fill_reg;
        phase_next = phase_reg;
        left_next  = left_reg;
        if (cmd.load)
        begin
            sh_next  = chunk;
            rem_next = RW'(n_sat);
        end
        else if (cmd.step)
        begin
            sh_next  = sh_reg >> take;
            rem_next = rem_after;
            if (done)
            begin
                buf_next   = '0;
                fill_next  = '0;
                phase_next = ph_after;
                left_next  = left_after;
            end
            else
            begin
                buf_next  = merged;
                fill_next = fill_sum;
            end
        end
        else if (cmd.finish_row)
        begin
            buf_next   = '0;
            fill_next  = '0;
            phase_next = PH_COLUMN;
            left_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            end_reg       <= 1'b0;
            buf_reg       <= '0;
            fill_reg      <= '0;
            phase_reg     <= PH_COLUMN;
            left_reg      <= '0;
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg   <= rem_next;
            buf_reg   <= buf_next;
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
            left_reg  <= left_next;
            if (cmd.load)
                end_reg <= row_end;
            if (cmd.finish_row)
                row_cnt_reg <= row_cnt_reg + ROW_NUMBER_BITS'(1);
            if (cmd.finish_row || (cmd.step && done))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        if (cmd.finish_row)
        begin
            out_kind_reg  <= KIND_ROW_END;
            out_value_reg <= FIELD_BITS'(row_cnt_reg);
            out_bad_reg   <= (phase_reg != PH_COLUMN) || (fill_reg != '0);
            out_last_reg  <= 1'b1;
        end
        else if (cmd.step && done)
        begin
            out_kind_reg  <= phase_kind(phase_reg);
            out_value_reg <= fvalue;
            out_bad_reg   <= 1'b0;
            out_last_reg  <= last_field;
        end
    end

    assign status.chunk_empty = (rem_reg == '0);
    assign status.row_end     = end_reg;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign field_value = out_value_reg;
    assign malformed   = out_bad_reg;
    assign last        = out_last_reg;

endmodule

// ----- design/packed_tuple_row_decoder.sv -----
// A field result is registered by a step on the loaded chunk, which waits for a free output; a
// row end is registered in ST_ROW_END, entered from ST_SCAN when the chunk runs empty after the
// last step, or after acceptance if no bits came. The field-assembly step completes one field
// per cycle while output is free; bits that leave a field open, row ends and control add steps.
// Reset is asynchronous and active low; it restores all width registers to 1 and the
// record state to the start of a row, and needs no clearing pass.
module packed_tuple_row_decoder
    import ptrd_pkg::*;
#(
    parameter int CHUNK_BITS = 32,
    parameter int ROW_NUMBER_BITS = 40
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WIDTH_BITS-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CHUNK_BITS-1:0]     chunk,
    input  logic [5:0]                chunk_bits,
    input  logic                      row_end,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                kind,
    output logic [FIELD_BITS-1:0]     field_value,
    output logic                      malformed,
    output logic                      last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ptrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ptrd_datapath #(
        .CHUNK_BITS      (CHUNK_BITS),
        .ROW_NUMBER_BITS (ROW_NUMBER_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .chunk       (chunk),
        .chunk_bits  (chunk_bits),
        .row_end     (row_end),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .kind        (kind),
        .field_value (field_value),
        .malformed   (malformed),
        .last        (last)
    );

endmodule

// ----- design/ptrd_checker.sv -----
// Port-level checks for the packed tuple row decoder, bound to the top level.
// Depends on ptrd_pkg for the result kind codes.
module ptrd_checker
    import ptrd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] kind,
    input logic       malformed,
    input logic       last
);

    // A pending result stays offered until its transfer completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transfer");

    // A row end is always the final result of its input transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ROW_END) |-> last)
        else $error("row end result without last");

    // Only a row end can report a malformed row.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_ROW_END) |-> !malformed)
        else $error("malformed set on a field result");

    // The decoder works on one input transfer at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

endmodule

bind packed_tuple_row_decoder ptrd_checker u_ptrd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .malformed (malformed),
    .last      (last)
);
